FILE: rtl/core/i2c_master_bit_engine_core_macros.svh
// Assertion helpers shared by the core RTL.
`ifndef I2C_MASTER_BIT_ENGINE_CORE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define I2CMBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define I2CMBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/i2cmbe_pkg.sv
package i2cmbe_pkg;

  localparam int PC_W          = 5;
  localparam int CNT_W         = 3;
  localparam int BITS_PER_BYTE = 8;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BITS_PER_BYTE - 1);

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_SACK  = 3'd4,
    OP_RACK  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ACT_SDA  = 2'd0,
    ACT_SCL  = 2'd1,
    ACT_READ = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    SRC_0   = 2'd0,
    SRC_1   = 2'd1,
    SRC_TX  = 2'd2,
    SRC_ACK = 2'd3
  } src_t;

  typedef enum logic [1:0] {
    RX_NONE = 2'd0,
    RX_BYTE = 2'd1,
    RX_ACK  = 2'd2
  } rx_t;

  typedef struct packed {
    act_t            act;
    src_t            src;
    rx_t             rx;
    logic            loop;    // repeat from target until bit count is done
    logic            stop;    // final step of the command
    logic [PC_W-1:0] target;
  } ucode_t;

  // Current step as seen by the datapath.
  typedef struct packed {
    logic busy;
    act_t act;
    src_t src;
    rx_t  rx;
    logic last;
  } step_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
    ucode_t w;
    w = ucode_t'{ACT_SCL, SRC_0, RX_NONE, 1'b0, 1'b1, '0};
    case (addr)
      // start
      5'd0:  w = ucode_t'{ACT_SDA,  SRC_1,   RX_NONE, 1'b0, 1'b0, '0};
      5'd1:  w = ucode_t'{ACT_SCL,  SRC_1,   RX_NONE, 1'b0, 1'b0, '0};
      5'd2:  w = ucode_t'{ACT_SDA,  SRC_0,   RX_NONE, 1'b0, 1'b0, '0};
      5'd3:  w = ucode_t'{ACT_SCL,  SRC_0,   RX_NONE, 1'b0, 1'b1, '0};
      // stop
      5'd4:  w = ucode_t'{ACT_SDA,  SRC_0,   RX_NONE, 1'b0, 1'b0, '0};
      5'd5:  w = ucode_t'{ACT_SCL,  SRC_1,   RX_NONE, 1'b0, 1'b0, '0};
      5'd6:  w = ucode_t'{ACT_SDA,  SRC_1,   RX_NONE, 1'b0, 1'b1, '0};
      // write byte
      5'd7:  w = ucode_t'{ACT_SDA,  SRC_TX,  RX_NONE, 1'b0, 1'b0, '0};
      5'd8:  w = ucode_t'{ACT_SCL,  SRC_1,   RX_NONE, 1'b0, 1'b0, '0};
      5'd9:  w = ucode_t'{ACT_SCL,  SRC_0,   RX_NONE, 1'b1, 1'b0, 5'd7};
      // read byte
      5'd10: w = ucode_t'{ACT_SDA,  SRC_1,   RX_NONE, 1'b0, 1'b0, '0};
      5'd11: w = ucode_t'{ACT_SCL,  SRC_1,   RX_NONE, 1'b0, 1'b0, '0};
      5'd12: w = ucode_t'{ACT_READ, SRC_1,   RX_NONE, 1'b0, 1'b0, '0};
      5'd13: w = ucode_t'{ACT_SCL,  SRC_0,   RX_BYTE, 1'b1, 1'b0, 5'd11};
      // send ack
      5'd14: w = ucode_t'{ACT_SDA,  SRC_ACK, RX_NONE, 1'b0, 1'b0, '0};
      5'd15: w = ucode_t'{ACT_SCL,  SRC_1,   RX_NONE, 1'b0, 1'b0, '0};
      5'd16: w = ucode_t'{ACT_SCL,  SRC_0,   RX_NONE, 1'b0, 1'b1, '0};
      // receive ack
      5'd17: w = ucode_t'{ACT_SDA,  SRC_1,   RX_NONE, 1'b0, 1'b0, '0};
      5'd18: w = ucode_t'{ACT_SCL,  SRC_1,   RX_NONE, 1'b0, 1'b0, '0};
      5'd19: w = ucode_t'{ACT_READ, SRC_1,   RX_NONE, 1'b0, 1'b0, '0};
      5'd20: w = ucode_t'{ACT_SCL,  SRC_0,   RX_ACK,  1'b0, 1'b1, '0};
      default: w = ucode_t'{ACT_SCL, SRC_0, RX_NONE, 1'b0, 1'b1, '0};
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] entry_pc(input op_t op);
    logic [PC_W-1:0] pc;
    pc = '0;
    case (op)
      OP_START: pc = 5'd0;
      OP_STOP:  pc = 5'd4;
      OP_WRITE: pc = 5'd7;
      OP_READ:  pc = 5'd10;
      OP_SACK:  pc = 5'd14;
      OP_RACK:  pc = 5'd17;
      default:  pc = '0;
    endcase
    return pc;
  endfunction

  function automatic logic op_known(input logic [2:0] op);
    logic ok;
    case (op)
      OP_START, OP_STOP, OP_WRITE, OP_READ, OP_SACK, OP_RACK: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

FILE: rtl/core/i2cmbe_seq.sv
module i2cmbe_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic [i2cmbe_pkg::PC_W-1:0]    entry,
  input  logic                           advance,
  output i2cmbe_pkg::step_t              step
);

  localparam int PcW  = i2cmbe_pkg::PC_W;
  localparam int CntW = i2cmbe_pkg::CNT_W;

  logic                busy;
  logic [PcW-1:0]      pc;
  logic [CntW-1:0]     cnt;
  i2cmbe_pkg::ucode_t  uc;
  logic                last;

  always_comb begin
    uc   = i2cmbe_pkg::ucode_rom(pc);
    last = uc.stop | (uc.loop & (cnt == i2cmbe_pkg::CNT_LAST));
    step = '{busy: busy, act: uc.act, src: uc.src, rx: uc.rx, last: last};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      pc   <= entry;
      cnt  <= '0;
    end else if (advance) begin
      if (last) begin
        busy <= 1'b0;
      end else if (uc.loop) begin
        pc  <= uc.target;
        cnt <= cnt + CntW'(1);
      end else begin
        pc <= pc + PcW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/i2c_master_bit_engine_core.sv
// I2C master bit engine. Each input item is one bus command (tuser = op: start,
// stop, write byte, read byte, send ack, receive ack) and comes out as a run of
// bus-slot items, one per line write or line read, each carrying the SCL level,
// the driven SDA level (1 = released) and a sample flag; tlast marks the final
// slot, which also carries the read byte or the received ack in rx_data. Slot
// counts: start 4, stop 3, write byte 24, read byte 25, send ack 3, receive
// ack 4; op codes 6 and 7 are taken and dropped without output. A microcode
// sequencer steps through a 21-word control ROM, one step per cycle whenever
// the output register is free, each step issuing one slot. The next command is
// taken while the final slot still waits in the output register. SCL and SDA
// levels carry over from command to command and reset to released.
module i2c_master_bit_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // tx_byte[7:0], ack_bit[8], line_levels[16:9], zero pad
  input  logic [2:0]  s_tuser,   // op[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl[0], sda[1], sample[2], rx_data[10:3], zero pad
  output logic        m_tlast
);

  i2cmbe_pkg::step_t step;

  logic       accept;
  logic       load;
  logic       advance;

  // command payload, held for the length of the command
  logic [7:0] tx_sh;      // MSB is the bit being driven
  logic       ack_r;
  logic [7:0] lines_r;

  // live bus levels
  logic       scl_level;
  logic       sda_level;
  logic       scl_next;
  logic       sda_next;
  logic       lvl;
  logic [7:0] rx_next;

  // output slot register
  logic       o_scl;
  logic       o_sda;
  logic       o_sample;
  logic [7:0] o_rx;

  assign s_tready = ~step.busy;
  assign accept   = s_tvalid & s_tready;
  assign load     = accept & i2cmbe_pkg::op_known(s_tuser);
  assign advance  = step.busy & (~m_tvalid | m_tready);

  i2cmbe_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .entry   (i2cmbe_pkg::entry_pc(i2cmbe_pkg::op_t'(s_tuser))),
    .advance (advance),
    .step    (step)
  );

  // datapath for the current control word
  always_comb begin
    case (step.src)
      i2cmbe_pkg::SRC_0:   lvl = 1'b0;
      i2cmbe_pkg::SRC_1:   lvl = 1'b1;
      i2cmbe_pkg::SRC_TX:  lvl = tx_sh[7];
      i2cmbe_pkg::SRC_ACK: lvl = ack_r;
      default:             lvl = 1'b1;
    endcase
    scl_next = scl_level;
    sda_next = sda_level;
    case (step.act)
      i2cmbe_pkg::ACT_SDA: sda_next = lvl;
      i2cmbe_pkg::ACT_SCL: scl_next = lvl;
      default: ;
    endcase
    rx_next = '0;
    if (step.last) begin
      case (step.rx)
        i2cmbe_pkg::RX_BYTE: rx_next = lines_r;
        i2cmbe_pkg::RX_ACK:  rx_next = {7'd0, lines_r[7]};
        default:             rx_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx_sh   <= s_tdata[7:0];
      ack_r   <= s_tdata[8];
      lines_r <= s_tdata[16:9];
    end else if (advance && step.act == i2cmbe_pkg::ACT_SDA &&
                 step.src == i2cmbe_pkg::SRC_TX) begin
      tx_sh <= {tx_sh[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scl_level <= 1'b1;
      sda_level <= 1'b1;
      m_tvalid  <= 1'b0;
    end else if (advance) begin
      scl_level <= scl_next;
      sda_level <= sda_next;
      m_tvalid  <= 1'b1;
    end else if (m_tready) begin
      m_tvalid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_scl    <= scl_next;
      o_sda    <= sda_next;
      o_sample <= (step.act == i2cmbe_pkg::ACT_READ);
      o_rx     <= rx_next;
      m_tlast  <= step.last;
    end
  end

  assign m_tdata = {5'd0, o_rx, o_sample, o_sda, o_scl};

`include "i2c_master_bit_engine_core_macros.svh"

  // Once the final slot is issued the engine is free for the next command.
  `I2CMBE_ASSERT_NEXT(a_free_after_last, advance && step.last, s_tready, "engine still busy after last slot")
  // SDA is only sampled while SCL is high.
  `I2CMBE_ASSERT_NOW(a_sample_scl_high, m_tvalid && o_sample, o_scl, "sample slot with SCL low")
  // Received data shows only on the final slot.
  `I2CMBE_ASSERT_NOW(a_rx_only_last, m_tvalid && !m_tlast, o_rx == 8'd0, "rx_data on non-final slot")

endmodule
